>>> hdl/xudr_pkg.sv
// Package for the xorshift dice roller: word types, status codes and the
// generator step function. No dependencies; every other file uses it.
package xudr_pkg;

	localparam int GEN_W = 64;
	localparam int SUM_W = 14;

	// Largest die count that a roll accepts.
	localparam logic [6:0] MAX_DICE = 7'd64;

	// Generator word loaded in place of a zero seed, and its reset value.
	localparam logic [GEN_W-1:0] GEN_DEFAULT = 64'h0000_0000_0000_ACE1;

	localparam logic CMD_ROLL   = 1'b0;
	localparam logic CMD_RESEED = 1'b1;

	// Result status codes. The front end also uses them to classify a job.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SIDES  = 2'd1;
	localparam logic [1:0] ST_DICE   = 2'd2;
	localparam logic [1:0] ST_RESEED = 2'd3;

	typedef struct packed {
		logic       command;
		logic [6:0] dice_count;
		logic [7:0] sides;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [7:0]       roll_value;
		logic [SUM_W-1:0] running_sum;
		logic             last;
	} res_t;

	// A classified command as it waits in the queue.
	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] dice_count;
		logic [7:0] sides;
	} job_t;

	typedef struct packed {
		logic             start;
		logic [GEN_W-1:0] dividend;
		logic [7:0]       divisor;
	} rem_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] rem;
	} rem_rsp_t;

	// One xorshift step with shifts 13, 7 and 17.
	function automatic logic [GEN_W-1:0] gen_step(input logic [GEN_W-1:0] x);
		logic [GEN_W-1:0] a;
		logic [GEN_W-1:0] b;
		a = x ^ (x << 13);
		b = a ^ (a >> 7);
		return b ^ (b << 17);
	endfunction

endpackage

>>> hdl/xudr_front.sv
// Front end of the dice roller: accepts command words, classifies them and
// holds them in a two-entry queue. Depends on xudr_pkg.
module xudr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  xudr_pkg::cmd_t   in_word,
	output logic             job_valid,
	output xudr_pkg::job_t   job,
	input  logic             job_take
);

	xudr_pkg::job_t q_mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	xudr_pkg::job_t new_job;
	logic           push;

	// Sides is checked before the dice count.
	always_comb begin
		new_job.dice_count = in_word.dice_count;
		new_job.sides      = in_word.sides;
		if (in_word.command == xudr_pkg::CMD_RESEED) begin
			new_job.kind = xudr_pkg::ST_RESEED;
		end else if (in_word.sides == 8'd0) begin
			new_job.kind = xudr_pkg::ST_SIDES;
		end else if (!(in_word.dice_count inside {[7'd1:xudr_pkg::MAX_DICE]})) begin
			new_job.kind = xudr_pkg::ST_DICE;
		end else begin
			new_job.kind = xudr_pkg::ST_OK;
		end
	end

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign job_valid = (cnt_q != 2'd0);
	assign job       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (job_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, job_take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hdl/xudr_rem.sv
// Serial remainder unit: 64-bit dividend by an 8-bit divisor, one dividend
// bit per cycle, restoring. Depends on xudr_pkg.
module xudr_rem (
	input  logic               clk,
	input  logic               arst_n,
	input  xudr_pkg::rem_req_t req,
	output xudr_pkg::rem_rsp_t rsp
);

	logic [xudr_pkg::GEN_W-1:0] shreg_q;
	logic [7:0]                 acc_q;
	logic [7:0]                 div_q;
	logic [6:0]                 cnt_q;
	logic                       done_q;
	logic [8:0]                 trial;

	assign trial = {acc_q, shreg_q[xudr_pkg::GEN_W-1]};

	always_ff @(posedge clk) begin
		if (req.start) begin
			shreg_q <= req.dividend;
			acc_q   <= 8'd0;
			div_q   <= req.divisor;
		end else if (cnt_q != 7'd0) begin
			shreg_q <= shreg_q << 1;
			if (trial >= {1'b0, div_q}) begin
				acc_q <= 8'(trial - {1'b0, div_q});
			end else begin
				acc_q <= trial[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 7'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 7'd1) && !req.start;
			if (req.start) begin
				cnt_q <= 7'(xudr_pkg::GEN_W);
			end else if (cnt_q != 7'd0) begin
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = acc_q;

endmodule

>>> hdl/xudr_back.sv
// Back end of the dice roller: sequencer, seed register, xorshift generator
// and output register. Depends on xudr_pkg and drives an xudr_rem unit.
module xudr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       job_valid,
	input  xudr_pkg::job_t             job,
	output logic                       job_take,
	input  logic                       seed_we,
	input  logic [xudr_pkg::GEN_W-1:0] seed_data,
	output xudr_pkg::rem_req_t         rem_req,
	input  xudr_pkg::rem_rsp_t         rem_rsp,
	output logic                       out_valid,
	input  logic                       out_stall,
	output xudr_pkg::res_t             out_word
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LIM   = 3'd1;
	localparam logic [2:0] S_STEP  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]                 state_q;
	logic [xudr_pkg::GEN_W-1:0] seed_q;
	logic [xudr_pkg::GEN_W-1:0] gen_q;
	logic [7:0]                 rm_q;
	logic [7:0]                 sides_q;
	logic [6:0]                 dice_q;
	logic [6:0]                 done_cnt_q;
	logic [xudr_pkg::SUM_W-1:0] sum_q;
	xudr_pkg::res_t             res_q;
	logic                       out_valid_q;
	xudr_pkg::res_t             out_q;
	logic                       out_free;
	logic                       reject;
	logic [7:0]                 value;
	logic [xudr_pkg::SUM_W-1:0] sum_next;

	assign out_free = !out_valid_q || !out_stall;
	assign job_take = (state_q == S_IDLE) && job_valid;

	// A word at or above the limit lies in the top (2^64-1 mod sides)+1 codes.
	assign reject   = (~gen_q[xudr_pkg::GEN_W-1:8] == '0) && (~gen_q[7:0] <= rm_q);
	assign value    = rem_rsp.rem + 8'd1;
	assign sum_next = sum_q + xudr_pkg::SUM_W'(value);

	always_comb begin
		rem_req.start    = 1'b0;
		rem_req.dividend = gen_q;
		rem_req.divisor  = sides_q;
		if (job_take && job.kind == xudr_pkg::ST_OK) begin
			rem_req.start    = 1'b1;
			rem_req.dividend = '1;
			rem_req.divisor  = job.sides;
		end else if (state_q == S_CHECK && !reject) begin
			rem_req.start = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				sides_q    <= job.sides;
				dice_q     <= job.dice_count;
				sum_q      <= '0;
				done_cnt_q <= 7'd0;
				res_q.status      <= job.kind;
				res_q.roll_value  <= 8'd0;
				res_q.running_sum <= '0;
				res_q.last        <= 1'b1;
			end
			S_LIM: begin
				if (rem_rsp.done) begin
					rm_q <= rem_rsp.rem;
				end
			end
			S_DIV: begin
				if (rem_rsp.done) begin
					sum_q      <= sum_next;
					done_cnt_q <= done_cnt_q + 7'd1;
					res_q.status      <= xudr_pkg::ST_OK;
					res_q.roll_value  <= value;
					res_q.running_sum <= sum_next;
					res_q.last        <= (done_cnt_q + 7'd1 == dice_q);
				end
			end
			default: begin
			end
		endcase
		if (out_free && state_q == S_OUT) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seed_q      <= xudr_pkg::GEN_DEFAULT;
			gen_q       <= xudr_pkg::GEN_DEFAULT;
			out_valid_q <= 1'b0;
		end else begin
			if (seed_we) begin
				seed_q <= seed_data;
			end
			if (out_free) begin
				out_valid_q <= (state_q == S_OUT);
			end
			case (state_q)
				S_IDLE: begin
					if (job_take) begin
						if (job.kind == xudr_pkg::ST_OK) begin
							state_q <= S_LIM;
						end else begin
							if (job.kind == xudr_pkg::ST_RESEED) begin
								gen_q <= (seed_q == '0) ? xudr_pkg::GEN_DEFAULT : seed_q;
							end
							state_q <= S_OUT;
						end
					end
				end
				S_LIM: begin
					if (rem_rsp.done) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					gen_q   <= xudr_pkg::gen_step(gen_q);
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= reject ? S_STEP : S_DIV;
				end
				S_DIV: begin
					if (rem_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= res_q.last ? S_IDLE : S_STEP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

>>> hdl/xorshift_unbiased_dice_roller.sv
// Top level of the xorshift dice roller: front end, queue, sequencer and
// serial remainder unit. Depends on xudr_pkg, xudr_front, xudr_rem, xudr_back.
//
//   Channel | Signals                        | Word
//   --------+--------------------------------+---------------------------------
//   input   | in_valid, in_stall, in_word    | command, dice_count, sides
//   output  | out_valid, out_stall, out_word | status, roll_value, running_sum,
//           |                                | last
//   config  | seed_we, seed_data             | 64-bit seed
//
// A reseed or an error word goes from the queue straight to the output state.
// A roll has the remainder unit find the rejection limit, then per die steps the
// generator, checks the word against the limit (stepping again on a rejection)
// and has the unit reduce it to a die value at one dividend bit per cycle.
// Reset clears queue, sequencer and output register and loads seed and generator
// with 0xACE1. The queue takes words while results wait, so input stalls when full.
module xorshift_unbiased_dice_roller (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  xudr_pkg::cmd_t             in_word,
	output logic                       out_valid,
	input  logic                       out_stall,
	output xudr_pkg::res_t             out_word,
	input  logic                       seed_we,
	input  logic [xudr_pkg::GEN_W-1:0] seed_data
);

	logic               job_valid;
	logic               job_take;
	xudr_pkg::job_t     job;
	xudr_pkg::rem_req_t rem_req;
	xudr_pkg::rem_rsp_t rem_rsp;

	// Classifies each accepted word and queues it for the sequencer.
	xudr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take)
	);

	// Shared remainder unit: first the limit remainder, then each die value.
	xudr_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// Steps the generator, rejects biased words and emits one word per die, reseed or bad command.
	xudr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.seed_we   (seed_we),
		.seed_data (seed_data),
		.rem_req   (rem_req),
		.rem_rsp   (rem_rsp),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

>>> verif/xorshift_unbiased_dice_roller_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for xorshift_unbiased_dice_roller. It drives command
// words and seed writes, predicts every result word and checks it on arrival.
// Depends on xudr_pkg and the RTL of the block; reads no files.

module xorshift_unbiased_dice_roller_test;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 10;
	// Worst quiet stretch in a correct run is the long output hold-off below,
	// or a limit computation plus one die under stalls.
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int HOLD_CYCLES = 500;
	// Cycles waited after the last result word so that the block settles
	// before a seed write.
	localparam int SETTLE_CYCLES = 10;
	localparam logic [xudr_pkg::GEN_W-1:0] ALL_ONES = {xudr_pkg::GEN_W{1'b1}};

	// Tracks the seed register and the generator word, turns each accepted
	// command word into the result words it must cause, and checks them.
	class roll_scoreboard;
		logic [xudr_pkg::GEN_W-1:0] seed_reg;
		logic [xudr_pkg::GEN_W-1:0] gen_state;
		xudr_pkg::res_t expected_rolls[$];
		int errors;
		int n_rolls;
		int n_dice;
		int n_reseeds;
		int n_bad_cmds;
		int n_results;

		function new();
			seed_reg = xudr_pkg::GEN_DEFAULT;
			gen_state = xudr_pkg::GEN_DEFAULT;
		endfunction

		function void add_result(logic [1:0] st, logic [7:0] val,
				logic [xudr_pkg::SUM_W-1:0] sum, logic fin);
			xudr_pkg::res_t r;
			r.status = st;
			r.roll_value = val;
			r.running_sum = sum;
			r.last = fin;
			expected_rolls.push_back(r);
		endfunction

		function void take_command(xudr_pkg::cmd_t c);
			logic [xudr_pkg::GEN_W-1:0] lim;
			logic [xudr_pkg::GEN_W-1:0] w;
			logic [xudr_pkg::GEN_W-1:0] rem;
			logic [xudr_pkg::SUM_W-1:0] total;
			if (c.command == xudr_pkg::CMD_RESEED) begin
				// A zero seed would lock the generator at zero.
				gen_state = (seed_reg == '0) ? xudr_pkg::GEN_DEFAULT : seed_reg;
				n_reseeds++;
				add_result(xudr_pkg::ST_RESEED, 8'd0, '0, 1'b1);
			end else if (c.sides == 8'd0) begin
				// The side count is checked before the die count.
				n_bad_cmds++;
				add_result(xudr_pkg::ST_SIDES, 8'd0, '0, 1'b1);
			end else if (c.dice_count == 7'd0 || c.dice_count > xudr_pkg::MAX_DICE) begin
				n_bad_cmds++;
				add_result(xudr_pkg::ST_DICE, 8'd0, '0, 1'b1);
			end else begin
				n_rolls++;
				// Largest multiple of the side count; words at or above it
				// are thrown away so that every face is equally likely.
				lim = ALL_ONES - (ALL_ONES % c.sides);
				total = '0;
				for (int i = 0; i < c.dice_count; i++) begin
					do begin
						w = gen_state;
						w = w ^ (w << 13);
						w = w ^ (w >> 7);
						w = w ^ (w << 17);
						gen_state = w;
					end while (w >= lim);
					rem = w % c.sides;
					total = total + rem[7:0] + 8'd1;
					n_dice++;
					add_result(xudr_pkg::ST_OK, rem[7:0] + 8'd1, total,
						i == c.dice_count - 1);
				end
			end
		endfunction

		function void compare_field(string field, logic [15:0] want_v, logic [15:0] got_v);
			if (got_v !== want_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v,
					got_v);
			end
		endfunction

		function void check_result(xudr_pkg::res_t got);
			xudr_pkg::res_t want;
			n_results++;
			if (expected_rolls.size() == 0) begin
				errors++;
				$display({"%0t: result word with nothing expected, actual status %0d",
					" value %0d sum %0d last %0d"},
					$time, got.status, got.roll_value, got.running_sum, got.last);
				return;
			end
			want = expected_rolls.pop_front();
			compare_field("status", 16'(want.status), 16'(got.status));
			compare_field("roll_value", 16'(want.roll_value), 16'(got.roll_value));
			compare_field("running_sum", 16'(want.running_sum), 16'(got.running_sum));
			compare_field("last", 16'(want.last), 16'(got.last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	xudr_pkg::cmd_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	xudr_pkg::res_t out_word;
	logic seed_we = 1'b0;
	logic [xudr_pkg::GEN_W-1:0] seed_data = '0;

	roll_scoreboard sb = new();

	// Idle rates in percent for the sender and the receiver.
	int send_idle_pct = 35;
	int recv_idle_pct = 35;
	// Set by the stimulus to ask the receiver for one long hold-off.
	bit hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int seed_writes = 0;

	xorshift_unbiased_dice_roller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.seed_we   (seed_we),
		.seed_data (seed_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Receiver: random stalls, plus one long hold-off counted here so that the
	// queue fills and the block has to stall its input.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Both channels are sampled at the rising edge, before any of this edge's
	// updates land. Every accepted command word feeds the predictor, every
	// accepted result word is checked, and a long quiet stretch ends the run.
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			sb.take_command(in_word);
		if (out_valid && !out_stall)
			sb.check_result(out_word);
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d results still expected", $time,
				WATCHDOG_LIMIT, sb.expected_rolls.size());
			$display("xorshift_unbiased_dice_roller_test NOT OK");
			$finish;
		end
	end

	// Offers one command word after a random number of idle cycles and returns
	// at the edge where it is taken. Valid stays high into the next call, which
	// either drops it for a gap or drives the next word straight away.
	task automatic send_cmd(input logic cmd, input logic [6:0] dice, input logic [7:0] sides);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= '{command: cmd, dice_count: dice, sides: sides};
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
	endtask

	// Stops sending and waits until every predicted result word has arrived
	// and the block has had time to settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_rolls.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the seed register; only called while the block is idle.
	task automatic write_seed(input logic [xudr_pkg::GEN_W-1:0] value);
		seed_we <= 1'b1;
		seed_data <= value;
		@(posedge clk);
		sb.seed_reg = value;
		seed_writes++;
		seed_we <= 1'b0;
	endtask

	// Mostly well-formed rolls with small dice counts, some reseeds, and a
	// share of words with a bad side count or a bad die count.
	task automatic random_phase(input int count);
		int pick;
		logic cmd;
		logic [6:0] dice;
		logic [7:0] sides;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			cmd = xudr_pkg::CMD_ROLL;
			dice = 7'($urandom_range(1, 6));
			sides = 8'($urandom_range(1, 255));
			if (pick < 8) begin
				cmd = xudr_pkg::CMD_RESEED;
				dice = 7'($urandom);
				sides = 8'($urandom);
			end else if (pick < 12) begin
				dice = 7'($urandom);
				sides = 8'd0;
			end else if (pick < 18) begin
				dice = ($urandom_range(2) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
				sides = 8'($urandom);
			end else begin
				if (pick < 35)
					sides = 8'($urandom_range(1, 8));
				else if (pick < 50)
					sides = 8'($urandom_range(128, 255));
				// Long rolls are kept rare since each die runs through the serial remainder unit.
				if (pick % 20 == 0)
					dice = 7'($urandom_range(40, 64));
				else if (pick % 5 == 0)
					dice = 7'($urandom_range(7, 24));
			end
			send_cmd(cmd, dice, sides);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset seed: the generator starts at 0xACE1.
		send_cmd(xudr_pkg::CMD_ROLL, 7'd1, 8'd6);
		send_cmd(xudr_pkg::CMD_ROLL, xudr_pkg::MAX_DICE, 8'd255);  // most dice, most faces
		send_cmd(xudr_pkg::CMD_ROLL, 7'd1, 8'd1);                  // one-sided die
		send_cmd(xudr_pkg::CMD_ROLL, xudr_pkg::MAX_DICE, 8'd1);
		send_cmd(xudr_pkg::CMD_ROLL, 7'd3, 8'd0);                  // no faces
		send_cmd(xudr_pkg::CMD_ROLL, 7'd0, 8'd0);      // side check wins over dice check
		send_cmd(xudr_pkg::CMD_ROLL, 7'd0, 8'd6);                  // no dice
		send_cmd(xudr_pkg::CMD_ROLL, 7'd65, 8'd6);                 // one die too many
		send_cmd(xudr_pkg::CMD_ROLL, 7'd127, 8'd255);
		send_cmd(xudr_pkg::CMD_RESEED, 7'd127, 8'd255);  // reseed from the reset seed
		send_cmd(xudr_pkg::CMD_ROLL, 7'd3, 8'd2);
		send_cmd(xudr_pkg::CMD_ROLL, 7'd2, 8'd128);
		wait_drained();

		// A zero seed must load the default word instead.
		write_seed('0);
		send_cmd(xudr_pkg::CMD_RESEED, 7'd0, 8'd0);
		send_cmd(xudr_pkg::CMD_ROLL, 7'd4, 8'd6);
		send_cmd(xudr_pkg::CMD_ROLL, xudr_pkg::MAX_DICE, 8'd0);  // error leaves the generator
		send_cmd(xudr_pkg::CMD_ROLL, 7'd1, 8'd255);
		wait_drained();

		write_seed(ALL_ONES);
		send_cmd(xudr_pkg::CMD_RESEED, 7'd5, 8'd9);
		send_cmd(xudr_pkg::CMD_ROLL, 7'd3, 8'd255);
		send_cmd(xudr_pkg::CMD_ROLL, 7'd2, 8'd7);
		wait_drained();

		// Random seed, normal idling, with one pause in the middle until the
		// block has delivered everything.
		write_seed({$urandom, $urandom});
		send_cmd(xudr_pkg::CMD_RESEED, 7'd0, 8'd0);
		random_phase(15);
		wait_drained();
		random_phase(15);
		wait_drained();

		// Long stretch with no idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_seed(64'd1);
		send_cmd(xudr_pkg::CMD_RESEED, 7'd0, 8'd0);
		random_phase(30);
		wait_drained();
		send_idle_pct = 35;
		recv_idle_pct = 35;

		// The receiver holds off for a long time while short words keep
		// coming, so the output register and the queue fill and the input
		// stalls.
		write_seed(64'h8000_0000_0000_0000);
		hold_req = 1'b1;
		send_cmd(xudr_pkg::CMD_RESEED, 7'd1, 8'd1);
		send_cmd(xudr_pkg::CMD_ROLL, 7'd2, 8'd6);
		send_cmd(xudr_pkg::CMD_ROLL, 7'd0, 8'd9);
		send_cmd(xudr_pkg::CMD_ROLL, 7'd1, 8'd0);
		send_cmd(xudr_pkg::CMD_ROLL, 7'd1, 8'd3);
		send_cmd(xudr_pkg::CMD_RESEED, 7'd64, 8'd200);
		random_phase(25);
		wait_drained();

		write_seed({$urandom, $urandom});
		send_cmd(xudr_pkg::CMD_RESEED, 7'd0, 8'd0);
		random_phase(25);
		wait_drained();

		$display("Run covered %0d rolls with %0d dice, %0d reseeds and %0d bad commands,",
			sb.n_rolls, sb.n_dice, sb.n_reseeds, sb.n_bad_cmds);
		$display("%0d seed writes, a long output hold-off and %0d result words checked.",
			seed_writes, sb.n_results);
		if (sb.errors == 0 && sb.expected_rolls.size() == 0) begin
			$display("xorshift_unbiased_dice_roller_test OK");
		end else begin
			$display("xorshift_unbiased_dice_roller_test NOT OK");
		end
		$finish;
	end

endmodule
